>>> rtl/jsjis_pkg.sv
package jsjis_pkg;

  typedef enum logic [1:0] {
    CODE_JIS  = 2'd0,
    CODE_EUC  = 2'd1,
    CODE_SJIS = 2'd2,
    CODE_RAW  = 2'd3
  } code_e;

  localparam logic [0:0] REG_INPUT_CODE = 1'b0;
  localparam logic [0:0] REG_FULL_WIDTH = 1'b1;

  localparam int unsigned MaxOut = 4;

  // one converted item: up to four bytes
  typedef struct packed {
    logic [2:0]       cnt;
    logic [3:0][7:0]  bytes;
  } obuf_t;

  function automatic logic [7:0] kana_trail(input logic [5:0] idx);
    logic [7:0] t;
    case (idx)
      6'd0: t = 8'd66;   6'd1: t = 8'd117;  6'd2: t = 8'd118;  6'd3: t = 8'd65;
      6'd4: t = 8'd69;   6'd5: t = 8'd146;  6'd6: t = 8'd64;   6'd7: t = 8'd66;
      6'd8: t = 8'd68;   6'd9: t = 8'd70;   6'd10: t = 8'd72;  6'd11: t = 8'd131;
      6'd12: t = 8'd133; 6'd13: t = 8'd135; 6'd14: t = 8'd98;  6'd15: t = 8'd91;
      6'd16: t = 8'd65;  6'd17: t = 8'd67;  6'd18: t = 8'd69;  6'd19: t = 8'd71;
      6'd20: t = 8'd73;  6'd21: t = 8'd74;  6'd22: t = 8'd76;  6'd23: t = 8'd78;
      6'd24: t = 8'd80;  6'd25: t = 8'd82;  6'd26: t = 8'd84;  6'd27: t = 8'd86;
      6'd28: t = 8'd88;  6'd29: t = 8'd90;  6'd30: t = 8'd92;  6'd31: t = 8'd94;
      6'd32: t = 8'd96;  6'd33: t = 8'd99;  6'd34: t = 8'd101; 6'd35: t = 8'd103;
      6'd36: t = 8'd105; 6'd37: t = 8'd106; 6'd38: t = 8'd107; 6'd39: t = 8'd108;
      6'd40: t = 8'd109; 6'd41: t = 8'd110; 6'd42: t = 8'd113; 6'd43: t = 8'd116;
      6'd44: t = 8'd119; 6'd45: t = 8'd122; 6'd46: t = 8'd125; 6'd47: t = 8'd126;
      6'd48: t = 8'd128; 6'd49: t = 8'd129; 6'd50: t = 8'd130; 6'd51: t = 8'd132;
      6'd52: t = 8'd134; 6'd53: t = 8'd136; 6'd54: t = 8'd137; 6'd55: t = 8'd138;
      6'd56: t = 8'd139; 6'd57: t = 8'd140; 6'd58: t = 8'd141; 6'd59: t = 8'd143;
      6'd60: t = 8'd147; 6'd61: t = 8'd74;  6'd62: t = 8'd75;
      default: t = 8'd66;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/japanese_text_to_shift_jis.sv
// Channel | dir | tdata                | tuser
// s_axis  | in  | [7:0] in_byte        | -  (tlast = end_of_text)
// m_axis  | out | [7:0] out_byte       | -  (tlast = last_of_run)
// cfg     | in  | cfg_wdata_i value    | -  (cfg_idx_i register, cfg_we_i strobe)
//
// A byte is converted in the cycle it is taken; its 0..4 output words sit
// in a result buffer and leave one word a cycle; m_axis_tready low holds
// them, and s_axis_tready is then low unless the buffer is empty. A new
// byte is taken in the same cycle the buffer's final word leaves. Reset
// (rst_ni) clears state, config and count, but not the result buffer.
module japanese_text_to_shift_jis (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);
  import jsjis_pkg::*;

  code_e      code_q;
  logic       full_q;
  logic       two_q, two_d, lp_q, lp_d;
  logic [1:0] esc_q, esc_d, kph_q, kph_d;
  logic [7:0] ld_q, ld_d, kn_q, kn_d;
  obuf_t      res;
  logic [3:0][7:0] buf_q;
  logic [2:0] cnt_q;   // words left
  logic [1:0] pos_q;   // next word
  logic       take, pop, last_w;

  jsjis_core u_core (
    .code_i(code_q), .full_i(full_q), .byte_i(s_axis_tdata), .eot_i(s_axis_tlast),
    .two_q_i(two_q), .esc_q_i(esc_q), .lead_q_i(ld_q), .lead_p_q_i(lp_q),
    .kana_q_i(kn_q), .kph_q_i(kph_q),
    .two_d_o(two_d), .esc_d_o(esc_d), .lead_d_o(ld_d), .lead_p_d_o(lp_d),
    .kana_d_o(kn_d), .kph_d_o(kph_d), .out_o(res)
  );

  assign m_axis_tvalid = cnt_q != 3'd0;
  assign m_axis_tdata  = buf_q[pos_q];
  assign last_w        = cnt_q == 3'd1;
  assign m_axis_tlast  = last_w;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !m_axis_tvalid || (pop && last_w);
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= CODE_JIS; full_q <= 1'b0;
      two_q <= 1'b0; esc_q <= '0; ld_q <= '0; lp_q <= 1'b0;
      kn_q <= '0; kph_q <= '0; cnt_q <= '0; pos_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_INPUT_CODE) code_q <= code_e'(cfg_wdata_i);
        else                              full_q <= cfg_wdata_i[0];
        two_q <= 1'b0; esc_q <= '0; ld_q <= '0; lp_q <= 1'b0;
        kn_q <= '0; kph_q <= '0;
      end else if (take) begin
        two_q <= two_d; esc_q <= esc_d; ld_q <= ld_d; lp_q <= lp_d;
        kn_q <= kn_d; kph_q <= kph_d;
      end
      if (take) begin
        cnt_q <= res.cnt; pos_q <= '0;
      end else if (pop) begin
        cnt_q <= cnt_q - 3'd1; pos_q <= pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) buf_q <= res.bytes;
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("buffer count overflow");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> (cnt_q == 3'd0 || (cnt_q == 3'd1 && m_axis_tready)))
    else $error("byte taken over pending words");
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !take) |=> cnt_q == $past(cnt_q) - 3'd1) else $error("pop count");
  a_eot_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && s_axis_tlast && !cfg_we_i) |=> (!lp_q && kph_q == 2'd0 && esc_q == 2'd0))
    else $error("state not cleared at end of text");
`endif

endmodule

>>> rtl/jsjis_core.sv
// Per-byte conversion: state and input byte in, up to four bytes and next state out.
module jsjis_core (
  input  jsjis_pkg::code_e code_i,
  input  logic             full_i,
  input  logic [7:0]       byte_i,
  input  logic             eot_i,
  input  logic             two_q_i,
  input  logic [1:0]       esc_q_i,
  input  logic [7:0]       lead_q_i,
  input  logic             lead_p_q_i,
  input  logic [7:0]       kana_q_i,
  input  logic [1:0]       kph_q_i,
  output logic             two_d_o,
  output logic [1:0]       esc_d_o,
  output logic [7:0]       lead_d_o,
  output logic             lead_p_d_o,
  output logic [7:0]       kana_d_o,
  output logic [1:0]       kph_d_o,
  output jsjis_pkg::obuf_t out_o
);
  import jsjis_pkg::*;

  function automatic logic is_hk(input logic [7:0] b);
    return b >= 8'd161 && b <= 8'd223;
  endfunction
  function automatic logic is_euc(input logic [7:0] b);
    return b >= 8'd161 && b <= 8'd254;
  endfunction
  function automatic logic can_maru(input logic [7:0] k);
    return k >= 8'd202 && k <= 8'd206;
  endfunction
  function automatic logic can_nig(input logic [7:0] k);
    return (k >= 8'd182 && k <= 8'd196) || can_maru(k) || k == 8'd179;
  endfunction

  obuf_t ob;

  // append with saturation at four bytes
  function automatic obuf_t put(input obuf_t o, input logic [7:0] b);
    obuf_t r;
    r = o;
    if (o.cnt < 3'(MaxOut)) begin
      r.bytes[o.cnt[1:0]] = b;
      r.cnt = o.cnt + 3'd1;
    end
    return r;
  endfunction

  function automatic obuf_t put_jis(input obuf_t o, input logic [7:0] c1,
                                    input logic [7:0] c2);
    logic [7:0] row, cell_add;
    logic [8:0] s;
    obuf_t r;
    row      = (c1 < 8'd95) ? 8'd112 : 8'd176;
    cell_add = c1[0] ? ((c2 > 8'd95) ? 8'd32 : 8'd31) : 8'd126;
    s        = {1'b0, c1} + 9'd1;
    r        = put(o, s[8:1] + row);
    r        = put(r, c2 + cell_add);
    return r;
  endfunction

  // mark: 0 none, 1 voiced, 2 semi-voiced
  function automatic obuf_t put_kana(input obuf_t o, input logic [7:0] k,
                                     input logic [1:0] mark);
    logic [7:0] idx, tr, ld;
    obuf_t r;
    idx = k - 8'd161;
    if (idx > 8'd62) idx = 8'd0;
    tr = kana_trail(idx[5:0]);
    ld = (idx <= 8'd4 || k == 8'd176 || k >= 8'd222) ? 8'd129 : 8'd131;
    if (mark == 2'd1) begin
      if ((tr >= 8'd74 && tr <= 8'd103) || (tr >= 8'd110 && tr <= 8'd122)) tr = tr + 8'd1;
      else if (ld == 8'd131 && tr == 8'd69) tr = 8'd148;
    end else if (mark == 2'd2 && tr >= 8'd110 && tr <= 8'd122) begin
      tr = tr + 8'd2;
    end
    r = put(o, ld);
    r = put(r, tr);
    return r;
  endfunction

  always_comb begin
    logic       two, lp, done;
    logic [1:0] esc, kph;
    logic [7:0] ld, kn;
    two = two_q_i; esc = esc_q_i; ld = lead_q_i; lp = lead_p_q_i;
    kn = kana_q_i; kph = kph_q_i; done = 1'b0;
    ob = '0;
    case (code_i)
      CODE_JIS: begin
        if (esc == 2'd1) begin
          two = (byte_i == 8'd75 || byte_i == 8'd36);
          esc = (byte_i == 8'd36 || byte_i == 8'd40) ? 2'd2 : 2'd0;
        end else if (esc >= 2'd2) begin
          esc = 2'd0;
        end else if (lp) begin
          lp = 1'b0;
          ob = put_jis(ob, ld, byte_i);
        end else if (byte_i == 8'd27) begin
          esc = 2'd1;
        end else if (byte_i == 8'd10 || byte_i == 8'd13) begin
          two = 1'b0;
          ob  = put(ob, byte_i);
        end else if (byte_i == 8'd12) begin
          two = two;
        end else if (two) begin
          ld = byte_i; lp = 1'b1;
        end else begin
          ob = put(ob, byte_i);
        end
      end
      CODE_EUC: begin
        if (kph == 2'd1) begin
          if (byte_i == 8'd142) begin
            kph = 2'd2; done = 1'b1;
          end else begin
            kph = 2'd0;
            ob  = put_kana(ob, kn, 2'd0);
          end
        end else if (kph >= 2'd2) begin
          kph = 2'd0;
          if (byte_i == 8'd222 && can_nig(kn)) begin
            ob = put_kana(ob, kn, 2'd1); done = 1'b1;
          end else if (byte_i == 8'd223 && can_maru(kn)) begin
            ob = put_kana(ob, kn, 2'd2); done = 1'b1;
          end else begin
            ob = put_kana(ob, kn, 2'd0);
            ld = 8'd142; lp = 1'b1;
          end
        end
        if (!done) begin
          if (lp) begin
            lp = 1'b0;
            if (ld == 8'd142) begin
              if (is_hk(byte_i)) begin
                if (full_i) begin
                  kn = byte_i; kph = 2'd1;
                end else begin
                  ob = put(ob, byte_i);
                end
              end else begin
                ob = put(ob, 8'd142);
                ob = put(ob, byte_i);
              end
            end else if (is_euc(byte_i)) begin
              ob = put_jis(ob, ld - 8'd128, byte_i - 8'd128);
            end else begin
              ob = put(ob, ld);
              ob = put(ob, byte_i);
            end
          end else if (byte_i == 8'd12) begin
            lp = 1'b0;
          end else if (is_euc(byte_i) || byte_i == 8'd142) begin
            ld = byte_i; lp = 1'b1;
          end else begin
            ob = put(ob, byte_i);
          end
        end
      end
      CODE_SJIS: begin
        if (kph != 2'd0) begin
          kph = 2'd0;
          if (byte_i == 8'd222 && can_nig(kn)) begin
            ob = put_kana(ob, kn, 2'd1); done = 1'b1;
          end else if (byte_i == 8'd223 && can_maru(kn)) begin
            ob = put_kana(ob, kn, 2'd2); done = 1'b1;
          end else begin
            ob = put_kana(ob, kn, 2'd0);
          end
        end
        if (!done) begin
          if (lp) begin
            lp = 1'b0;
            if (byte_i >= 8'd64 && byte_i <= 8'd252) begin
              ob = put(ob, ld);
              ob = put(ob, byte_i);
            end
          end else if (byte_i == 8'd10 || byte_i == 8'd13) begin
            ob = put(ob, 8'd13);
          end else if (byte_i == 8'd0 || byte_i == 8'd12) begin
            lp = 1'b0;
          end else if ((byte_i >= 8'd129 && byte_i <= 8'd159) ||
                       (byte_i >= 8'd224 && byte_i <= 8'd239)) begin
            ld = byte_i; lp = 1'b1;
          end else if (is_hk(byte_i) && full_i) begin
            kn = byte_i; kph = 2'd1;
          end else begin
            ob = put(ob, byte_i);
          end
        end
      end
      default: ob = put(ob, byte_i);
    endcase
    if (eot_i) begin
      if (kph != 2'd0) begin
        ob = put_kana(ob, kn, 2'd0);
        if (kph >= 2'd2) ob = put(ob, 8'd142);
      end
      if (lp) ob = put(ob, ld);
      two = 1'b0; esc = 2'd0; ld = '0; lp = 1'b0; kn = '0; kph = 2'd0;
    end
    two_d_o = two; esc_d_o = esc; lead_d_o = ld; lead_p_d_o = lp;
    kana_d_o = kn; kph_d_o = kph;
  end

  assign out_o = ob;

endmodule

>>> tb/sjis_checker.sv
module sjis_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       s_valid_i,
  input  logic       s_ready_i,
  input  logic [7:0] s_data_i,
  input  logic       s_last_i,
  input  logic       m_valid_i,
  input  logic       m_ready_i,
  input  logic [7:0] m_data_i,
  input  logic       m_last_i,
  output int         fail_cnt_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import jsjis_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } sjis_word_t;

  code_e      src_code;
  logic       widen_kana;
  logic       dbl_mode;
  logic [1:0] esc_ph;
  logic [7:0] lead;
  logic       lead_vld;
  logic [7:0] kana;
  logic [1:0] kana_ph;
  logic [7:0] step_buf [$];
  sjis_word_t expected_bytes [$];

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp);
    $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, exp);
    fail_cnt_o++;
  endtask

  function automatic void put_byte(input logic [7:0] b);
    if (step_buf.size() < MaxOut) step_buf.push_back(b);
  endfunction

  function automatic void clear_conv();
    dbl_mode = 1'b0; esc_ph = 2'd0; lead = 8'd0; lead_vld = 1'b0;
    kana = 8'd0; kana_ph = 2'd0;
  endfunction

  function automatic void put_jis(input logic [7:0] c1, input logic [7:0] c2);
    logic [7:0] row, cellv;
    row   = (c1 < 95) ? 8'd112 : 8'd176;
    cellv = c1[0] ? (8'd31 + (c2 > 95 ? 8'd1 : 8'd0)) : 8'd126;
    put_byte(8'((({1'b0, c1} + 9'd1) >> 1)) + row);
    put_byte(c2 + cellv);
  endfunction

  function automatic logic [7:0] trail_of(input int idx);
    logic [7:0] t [63] = '{66, 117, 118, 65, 69, 146, 64, 66, 68, 70, 72, 131, 133,
      135, 98, 91, 65, 67, 69, 71, 73, 74, 76, 78, 80, 82, 84, 86, 88, 90, 92, 94,
      96, 99, 101, 103, 105, 106, 107, 108, 109, 110, 113, 116, 119, 122, 125, 126,
      128, 129, 130, 132, 134, 136, 137, 138, 139, 140, 141, 143, 147, 74, 75};
    return t[idx];
  endfunction

  // mark: 0 plain, 1 voiced, 2 semi-voiced
  function automatic void put_wide_kana(input logic [7:0] k, input int mark);
    int idx;
    logic [7:0] ld, tr;
    idx = (k - 8'd161) & 8'hff;
    if (idx > 62) idx = 0;
    tr = trail_of(idx);
    ld = (idx <= 4 || k == 176 || k >= 222) ? 8'd129 : 8'd131;
    if (mark == 1) begin
      if ((tr >= 74 && tr <= 103) || (tr >= 110 && tr <= 122)) tr = tr + 8'd1;
      else if (ld == 131 && tr == 69) tr = 8'd148;
    end else if (mark == 2 && tr >= 110 && tr <= 122) begin
      tr = tr + 8'd2;
    end
    put_byte(ld);
    put_byte(tr);
  endfunction

  function automatic bit half_kana(input logic [7:0] b);
    return b >= 161 && b <= 223;
  endfunction
  function automatic bit euc_byte(input logic [7:0] b);
    return b >= 161 && b <= 254;
  endfunction
  function automatic bit maru_ok(input logic [7:0] k);
    return k >= 202 && k <= 206;
  endfunction
  function automatic bit nigori_ok(input logic [7:0] k);
    return (k >= 182 && k <= 196) || maru_ok(k) || k == 179;
  endfunction

  function automatic void conv_jis(input logic [7:0] b);
    if (esc_ph == 2'd1) begin
      dbl_mode = (b == "K" || b == "$");
      esc_ph   = (b == "$" || b == "(") ? 2'd2 : 2'd0;
    end else if (esc_ph >= 2'd2) begin
      esc_ph = 2'd0;
    end else if (lead_vld) begin
      lead_vld = 1'b0;
      put_jis(lead, b);
    end else if (b == 27) esc_ph = 2'd1;
    else if (b == 10 || b == 13) begin
      dbl_mode = 1'b0;
      put_byte(b);
    end else if (b == 12) begin
    end else if (dbl_mode) begin
      lead = b;
      lead_vld = 1'b1;
    end else put_byte(b);
  endfunction

  function automatic void conv_euc(input logic [7:0] b);
    logic [7:0] a;
    if (kana_ph == 2'd1) begin
      if (b == 142) begin
        kana_ph = 2'd2;
        return;
      end
      kana_ph = 2'd0;
      put_wide_kana(kana, 0);
    end else if (kana_ph >= 2'd2) begin
      kana_ph = 2'd0;
      if (b == 222 && nigori_ok(kana)) begin
        put_wide_kana(kana, 1);
        return;
      end
      if (b == 223 && maru_ok(kana)) begin
        put_wide_kana(kana, 2);
        return;
      end
      put_wide_kana(kana, 0);
      lead = 8'd142;
      lead_vld = 1'b1;
    end
    if (lead_vld) begin
      a = lead;
      lead_vld = 1'b0;
      if (a == 142) begin
        if (half_kana(b)) begin
          if (widen_kana) begin
            kana = b;
            kana_ph = 2'd1;
          end else put_byte(b);
        end else begin
          put_byte(8'd142);
          put_byte(b);
        end
      end else if (euc_byte(b)) put_jis(a - 8'd128, b - 8'd128);
      else begin
        put_byte(a);
        put_byte(b);
      end
      return;
    end
    if (b == 12) return;
    if (euc_byte(b) || b == 142) begin
      lead = b;
      lead_vld = 1'b1;
    end else put_byte(b);
  endfunction

  function automatic void conv_sjis(input logic [7:0] b);
    if (kana_ph != 2'd0) begin
      kana_ph = 2'd0;
      if (b == 222 && nigori_ok(kana)) begin
        put_wide_kana(kana, 1);
        return;
      end
      if (b == 223 && maru_ok(kana)) begin
        put_wide_kana(kana, 2);
        return;
      end
      put_wide_kana(kana, 0);
    end
    if (lead_vld) begin
      lead_vld = 1'b0;
      if (b >= 64 && b <= 252) begin
        put_byte(lead);
        put_byte(b);
      end
      return;
    end
    if (b == 10 || b == 13) put_byte(8'd13);
    else if (b == 0 || b == 12) begin
    end else if ((b >= 129 && b <= 159) || (b >= 224 && b <= 239)) begin
      lead = b;
      lead_vld = 1'b1;
    end else if (half_kana(b) && widen_kana) begin
      kana = b;
      kana_ph = 2'd1;
    end else put_byte(b);
  endfunction

  function automatic void predict_word(input logic [7:0] b, input logic eot);
    step_buf.delete();
    case (src_code)
      CODE_JIS:  conv_jis(b);
      CODE_EUC:  conv_euc(b);
      CODE_SJIS: conv_sjis(b);
      default:   put_byte(b);
    endcase
    if (eot) begin
      if (kana_ph != 2'd0) begin
        put_wide_kana(kana, 0);
        if (kana_ph >= 2'd2) put_byte(8'd142);
      end
      if (lead_vld) put_byte(lead);
      clear_conv();
    end
    foreach (step_buf[k])
      expected_bytes.push_back('{step_buf[k], k == step_buf.size() - 1});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sjis_word_t w;
    if (!rst_ni) begin
      src_code = CODE_JIS;
      widen_kana = 1'b0;
      clear_conv();
      expected_bytes.delete();
      fail_cnt_o = 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected word", m_data_i, 8'd0);
        end else begin
          w = expected_bytes.pop_front();
          if (m_data_i !== w.ch) report_mismatch("out_byte", m_data_i, w.ch);
          if (m_last_i !== w.last) report_mismatch("last_of_run", m_last_i, w.last);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_INPUT_CODE) src_code = code_e'(cfg_wdata_i);
        else widen_kana = cfg_wdata_i[0];
        clear_conv();
      end
      if (s_valid_i && s_ready_i) predict_word(s_data_i, s_last_i);
    end
    pending_o = expected_bytes.size();
  end
endmodule

>>> tb/tb_japanese_text_to_shift_jis.sv
module tb_japanese_text_to_shift_jis;
  timeunit 1ns;
  timeprecision 1ps;
  import jsjis_pkg::*;

  localparam int StallLimit = 4000;

  logic       clk_i, rst_ni;
  logic       cfg_we_i, cfg_idx_i;
  logic [1:0] cfg_wdata_i;
  logic       s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [7:0] s_axis_tdata;   // [7:0] in_byte
  logic       m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [7:0] m_axis_tdata;   // [7:0] out_byte
  int         fail_cnt, pending;
  bit         sink_idle_ok;   // random back-pressure allowed
  bit         long_hold;      // request one long receiver stall
  int         idle_cycles;

  japanese_text_to_shift_jis u_top (.*);

  sjis_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready),
    .s_data_i(s_axis_tdata), .s_last_i(s_axis_tlast),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_i(m_axis_tdata), .m_last_i(m_axis_tlast),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("japanese_text_to_shift_jis regression: fail");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    bit hold_done;
    hold_done = 0;
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold && !hold_done) begin
        hold_done = 1;
        m_axis_tready <= 0;
        repeat (60) @(negedge clk_i);
        m_axis_tready <= 1;
      end else if (sink_idle_ok && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        m_axis_tready <= 0;
        repeat (n - 1) @(negedge clk_i);
      end else m_axis_tready <= 1;
    end
  end

  task automatic cfg_write(input logic idx, input logic [1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  // block must be idle before a register write: stop sending, drain, spare cycles
  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // tvalid stays up after the word is taken; the next call or drain() moves it
  task automatic send_byte(input int b, input int eot, input int gaps);
    int n;
    if (gaps != 0 && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 7);
      s_axis_tvalid <= 0;
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid <= 1; s_axis_tdata <= 8'(b); s_axis_tlast <= (eot != 0);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // text for the given code: well-formed sequences mixed with random bytes
  task automatic send_text(input code_e c, input int gaps);
    int len, k, r, b;
    len = $urandom_range(2, 10);
    for (k = 0; k < len; k++) begin
      r = $urandom_range(0, 9);
      b = $urandom_range(0, 255);
      case (c)
        CODE_JIS: begin
          if (r == 0) begin
            send_byte(27, 0, gaps);
            send_byte(($urandom_range(0, 1)) ? "$" : "(", 0, gaps);
            send_byte("B", 0, gaps);
          end else if (r < 7) begin
            send_byte($urandom_range(33, 126), 0, gaps);
          end else send_byte(b, 0, gaps);
        end
        CODE_EUC: begin
          if (r < 4) begin
            send_byte($urandom_range(161, 254), 0, gaps);
            send_byte($urandom_range(161, 254), 0, gaps);
          end else if (r < 7) begin
            send_byte(142, 0, gaps);
            send_byte($urandom_range(161, 223), 0, gaps);
          end else send_byte(b, 0, gaps);
        end
        CODE_SJIS: begin
          if (r < 3) begin
            send_byte($urandom_range(129, 159), 0, gaps);
            send_byte($urandom_range(64, 252), 0, gaps);
          end else if (r < 7) begin
            send_byte($urandom_range(161, 223), 0, gaps);
          end else send_byte(b, 0, gaps);
        end
        default: send_byte(b, 0, gaps);
      endcase
    end
    send_byte($urandom_range(0, 255), 1, gaps);
  endtask

  initial begin
    int ph;
    cfg_we_i = 0; cfg_idx_i = 0; cfg_wdata_i = 0;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tlast = 0;
    sink_idle_ok = 0; long_hold = 0;
    rst_ni = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;

    // directed: JIS escapes, pairs, line ends, form feed, extremes
    send_byte(8'd0, 0, 0);
    send_byte(8'd255, 0, 0);
    send_byte(27, 0, 0); send_byte("$", 0, 0); send_byte("B", 0, 0);
    send_byte(8'h30, 0, 0); send_byte(8'h21, 0, 0);
    send_byte(8'hff, 0, 0); send_byte(8'h7e, 0, 0);
    send_byte(12, 0, 0); send_byte(10, 0, 0);
    send_byte(27, 0, 0); send_byte("K", 0, 0); send_byte(8'h41, 1, 0); // lead held at end
    drain();
    // EUC with kana widening: voiced and semi-voiced marks, unmerged mark, flush
    cfg_write(REG_INPUT_CODE, CODE_EUC);
    cfg_write(REG_FULL_WIDTH, 2'd1);
    send_byte(142, 0, 0); send_byte(182, 0, 0); send_byte(142, 0, 0); send_byte(222, 0, 0);
    send_byte(142, 0, 0); send_byte(202, 0, 0); send_byte(142, 0, 0); send_byte(223, 0, 0);
    send_byte(142, 0, 0); send_byte(161, 0, 0); send_byte(142, 0, 0); send_byte(200, 0, 0);
    send_byte(142, 0, 0); send_byte(177, 0, 0); send_byte(142, 1, 0);
    drain();
    // SJIS: NUL, invalid pair (LF as trail), valid pair, voiced kana
    cfg_write(REG_INPUT_CODE, CODE_SJIS);
    send_byte(0, 0, 0); send_byte(129, 0, 0); send_byte(10, 0, 0);
    send_byte(224, 0, 0); send_byte(64, 0, 0); send_byte(179, 0, 0); send_byte(222, 1, 0);
    drain();
    cfg_write(REG_INPUT_CODE, CODE_RAW);
    send_byte(8'h5a, 1, 0);
    drain();

    // random phases through every setting; back-pressure on
    sink_idle_ok = 1;
    for (ph = 0; ph < 16; ph++) begin
      cfg_write(REG_INPUT_CODE, code_e'(ph % 4));
      cfg_write(REG_FULL_WIDTH, 2'((ph / 4) % 2));
      if (ph == 5) long_hold = 1;   // sender keeps offering while sink holds off
      repeat (2) begin
        send_text(code_e'(ph % 4), 1);
        if ($urandom_range(0, 3) == 0) send_byte($urandom_range(0, 255), 1, 1);
      end
      if (ph == 9) drain();         // sender pause until all results are in
      drain();
    end

    // final stretch with no idling on either side
    sink_idle_ok = 0;
    cfg_write(REG_INPUT_CODE, CODE_EUC);
    repeat (6) send_text(CODE_EUC, 0);
    drain();
    repeat (10) @(negedge clk_i);
    if (fail_cnt == 0 && pending == 0)
      $display("japanese_text_to_shift_jis regression: pass");
    else
      $display("japanese_text_to_shift_jis regression: fail");
    $finish;
  end
endmodule
